[hw/rtl/spfc_pkg.sv]
`default_nettype none

package spfc_pkg;

  // Fixed field widths
  localparam int unsigned FREQ_W   = 22;
  localparam int unsigned MANUAL_W = 9;
  localparam int unsigned PPK_W    = 16;
  localparam int unsigned SPEED_W  = 32;
  localparam int unsigned SET_W    = 24;
  localparam int unsigned OFREQ_W  = 25;
  localparam int unsigned DIVR_W   = 16;

  // Conversion constants
  localparam logic [9:0]        MHZ_TO_MPH    = 10'd1000;
  localparam logic signed [SET_W-1:0] SPEED_MAX_KMPH = 24'sd250;
  localparam logic signed [SET_W-1:0] SPEED_MIN_KMPH = -24'sd50;
  localparam logic [MANUAL_W-1:0] MANUAL_RESET = 9'd75;

  // m/h to km/h: floor(x / 1000) == (x * ceil(2^38 / 1000)) >> 38 for any 32-bit x
  localparam int unsigned KMPH_RECIP_W = 29;
  localparam int unsigned KMPH_SHIFT   = 38;
  localparam logic [KMPH_RECIP_W-1:0] KMPH_RECIP = 29'd274877907;

  // Request kinds on the input tuser
  localparam logic REQ_CAPTURE = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  // Register map, word index
  typedef enum logic [1:0] {
    REG_OUTPUT_MODE  = 2'd0,
    REG_MANUAL_SPEED = 2'd1,
    REG_IN_PPK       = 2'd2,
    REG_OUT_PPK      = 2'd3
  } reg_idx_e;

  // Operand selection for the shared divider
  typedef enum logic [1:0] {
    DIV_READING,
    DIV_AVERAGE
  } div_sel_e;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_DIV,
    ST_AVG,
    ST_AVG_WAIT,
    ST_KMPH,
    ST_CHECK,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic                    manual_mode;
    logic [MANUAL_W-1:0]     manual_speed;
    logic [PPK_W-1:0]        in_ppk;
    logic [PPK_W-1:0]        out_ppk;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic     cap_we;
    logic     tick_init;
    logic     clr_speed;
    logic     div_start;
    div_sel_e div_sel;
    logic     acc;
    logic     avg_done;
    logic     set_load;
    logic     upd_freq;
    logic     out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic meas_en;
    logic cnt_zero;
    logic last_reading;
    logic div_busy;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[hw/rtl/spfc_div.sv]
`default_nettype none

module spfc_div #(
  parameter int unsigned DW = 36
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [DW-1:0]                  dividend_i,
  input  wire logic [spfc_pkg::DIVR_W-1:0]    divisor_i,
  output logic                                busy_o,
  output logic                                done_o,
  output logic [DW-1:0]                       quotient_o
);
  import spfc_pkg::*;

  localparam int unsigned CNT_W = $clog2(DW + 1);

  logic [DW-1:0]     dq_q, dq_d;
  logic [DIVR_W-1:0] rem_q, rem_d;
  logic [DIVR_W-1:0] dvs_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              done_q;
  logic [DIVR_W:0]   trial;
  logic [DIVR_W:0]   diff;
  logic              ge;

  // One quotient bit per cycle, restoring
  always_comb begin
    trial = {rem_q, dq_q[DW-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = (trial >= {1'b0, dvs_q});
    dq_d  = dq_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (start_i) begin
      dq_d  = dividend_i;
      rem_d = '0;
      cnt_d = CNT_W'(DW);
    end else if (cnt_q != '0) begin
      dq_d  = {dq_q[DW-2:0], ge};
      rem_d = ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= !start_i && (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign busy_o     = (cnt_q != '0);
  assign done_o     = done_q;
  assign quotient_o = dq_q;

  // Completion only follows a running division
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("divider done without a running division");

endmodule

`default_nettype wire

[hw/rtl/spfc_datapath.sv]
`default_nettype none

module spfc_datapath #(
  parameter int unsigned RING_DEPTH = 10
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire spfc_pkg::cfg_t                  cfg_i,
  input  wire spfc_pkg::cmd_t                  cmd_i,
  output spfc_pkg::sts_t                       sts_o,
  input  wire logic [spfc_pkg::FREQ_W-1:0]     freq_i,
  output logic                                 m_valid_o,
  input  wire logic                            m_ready_i,
  output logic [spfc_pkg::OFREQ_W-1:0]         out_freq_o,
  output logic [spfc_pkg::SET_W-1:0]           set_speed_o,
  output logic [spfc_pkg::SPEED_W-1:0]         veh_speed_o,
  output logic                                 out_of_range_o
);
  import spfc_pkg::*;

  localparam int unsigned IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);
  localparam int unsigned SUM_W = SPEED_W + $clog2(RING_DEPTH);
  localparam int unsigned KPROD_W = SPEED_W + KMPH_RECIP_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

  // Ring of raw captured frequencies
  logic [FREQ_W-1:0] ring_mem [RING_DEPTH];
  logic [FREQ_W-1:0] rdata_q;

  logic [IDX_W-1:0]  wr_idx_q, rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q, k_q;
  logic [SUM_W-1:0]  sum_q;
  logic [SPEED_W-1:0] vspeed_q;
  logic signed [SET_W-1:0]   set_q;
  logic signed [OFREQ_W-1:0] freq_q;
  logic              bad_q;
  logic              m_valid_q;

  // Result register, held while the receiver stalls
  logic [OFREQ_W-1:0] res_freq_q;
  logic [SET_W-1:0]   res_set_q;
  logic [SPEED_W-1:0] res_speed_q;
  logic               res_bad_q;

  logic [SUM_W-1:0]  div_dividend;
  logic [DIVR_W-1:0] div_divisor;
  logic [SUM_W-1:0]  div_quot;
  logic              div_busy, div_done;
  logic [SPEED_W-1:0] scaled;
  logic [KPROD_W-1:0] kmph_prod;
  logic signed [OFREQ_W:0] product;
  logic              bad;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_we) begin
      ring_mem[wr_idx_q] <= freq_i;
    end
    rdata_q <= ring_mem[rd_ptr_q];
  end

  // Divider operand selection
  assign scaled = SPEED_W'(rdata_q) * SPEED_W'(MHZ_TO_MPH);

  always_comb begin
    div_dividend = SUM_W'(scaled);
    div_divisor  = cfg_i.in_ppk;
    case (cmd_i.div_sel)
      DIV_AVERAGE: begin
        div_dividend = sum_q;
        div_divisor  = DIVR_W'(cnt_q);
      end
      default: begin
        div_dividend = SUM_W'(scaled);
        div_divisor  = cfg_i.in_ppk;
      end
    endcase
  end

  spfc_div #(
    .DW (SUM_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Vehicle speed in km/h by reciprocal multiplication
  assign kmph_prod = KPROD_W'(vspeed_q) * KPROD_W'(KMPH_RECIP);

  // Range check and output scaling
  assign bad     = (set_q > SPEED_MAX_KMPH) || (set_q < SPEED_MIN_KMPH);
  assign product = $signed(set_q[MANUAL_W-1:0]) * $signed({1'b0, cfg_i.out_ppk});

  // Ring write index, reading count, held speed, drive frequency and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      cnt_q    <= '0;
      vspeed_q <= '0;
      freq_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cap_we) begin
        wr_idx_q <= (wr_idx_q == LAST_IDX) ? '0 : wr_idx_q + 1'b1;
        if (cnt_q != CNT_W'(RING_DEPTH)) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (cmd_i.clr_speed) begin
        vspeed_q <= '0;
      end
      if (cmd_i.avg_done) begin
        vspeed_q <= div_quot[SPEED_W-1:0];
        cnt_q    <= '0;
      end
      if (cmd_i.upd_freq && !bad) begin
        freq_q <= product[OFREQ_W-1:0];
      end
      if (cmd_i.out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Tick working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_init) begin
      rd_ptr_q <= (wr_idx_q == '0) ? LAST_IDX : wr_idx_q - 1'b1;
      k_q      <= '0;
      sum_q    <= '0;
    end
    if (cmd_i.acc) begin
      rd_ptr_q <= (rd_ptr_q == '0) ? LAST_IDX : rd_ptr_q - 1'b1;
      k_q      <= k_q + 1'b1;
      sum_q    <= sum_q + SUM_W'(div_quot[SPEED_W-1:0]);
    end
    if (cmd_i.set_load) begin
      if (cfg_i.manual_mode) begin
        set_q <= SET_W'($signed(cfg_i.manual_speed));
      end else begin
        set_q <= SET_W'(kmph_prod[KPROD_W-1:KMPH_SHIFT]);
      end
    end
    if (cmd_i.upd_freq) begin
      bad_q <= bad;
    end
  end

  // Result register load
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_freq_q  <= freq_q;
      res_set_q   <= set_q;
      res_speed_q <= vspeed_q;
      res_bad_q   <= bad_q;
    end
  end

  always_comb begin
    sts_o.meas_en      = (cfg_i.in_ppk != '0);
    sts_o.cnt_zero     = (cnt_q == '0);
    sts_o.last_reading = (CNT_W'(k_q + 1'b1) == cnt_q);
    sts_o.div_busy     = div_busy;
    sts_o.div_done     = div_done;
    sts_o.out_free     = !m_valid_q || m_ready_i;
  end

  assign m_valid_o      = m_valid_q;
  assign out_freq_o     = res_freq_q;
  assign set_speed_o    = res_set_q;
  assign veh_speed_o    = res_speed_q;
  assign out_of_range_o = res_bad_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(RING_DEPTH))
    else $error("reading count beyond ring depth");

  a_wr_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_idx_q <= LAST_IDX)
    else $error("ring write index out of range");

endmodule

`default_nettype wire

[hw/rtl/spfc_ctrl.sv]
`default_nettype none

module spfc_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           s_valid_i,
  input  wire logic           s_kind_i,
  output logic                s_ready_o,
  input  wire spfc_pkg::sts_t sts_i,
  output spfc_pkg::cmd_t      cmd_o
);
  import spfc_pkg::*;

  state_e state_q, state_d;
  logic   is_tick;

  assign is_tick = (s_kind_i == REQ_TICK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i && is_tick) begin
          if (sts_i.meas_en && !sts_i.cnt_zero) begin
            state_d = ST_READ;
          end else begin
            state_d = ST_KMPH;
          end
        end
      end
      ST_READ:  state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_DIV;
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = sts_i.last_reading ? ST_AVG : ST_READ;
        end
      end
      ST_AVG:   state_d = ST_AVG_WAIT;
      ST_AVG_WAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_KMPH;
        end
      end
      ST_KMPH:  state_d = ST_CHECK;
      ST_CHECK: state_d = ST_OUT;
      ST_OUT: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o     = '0;
    cmd_o.div_sel = DIV_READING;
    s_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.cap_we    = !is_tick;
          cmd_o.tick_init = is_tick;
          cmd_o.clr_speed = is_tick && sts_i.meas_en && sts_i.cnt_zero;
        end
      end
      ST_LOAD: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_READING;
      end
      ST_DIV: begin
        cmd_o.acc = sts_i.div_done;
      end
      ST_AVG: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_AVERAGE;
      end
      ST_AVG_WAIT: begin
        cmd_o.div_sel  = DIV_AVERAGE;
        cmd_o.avg_done = sts_i.div_done;
      end
      ST_KMPH: begin
        cmd_o.set_load = 1'b1;
      end
      ST_CHECK: begin
        cmd_o.upd_freq = 1'b1;
      end
      ST_OUT: begin
        cmd_o.out_load = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !sts_i.div_busy)
    else $error("divider started while busy");

  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result register overwritten");

  a_acc_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.acc || cmd_o.avg_done) |-> sts_i.div_done)
    else $error("quotient taken before division finished");

endmodule

`default_nettype wire

[hw/rtl/speed_pulse_frequency_converter.sv]
// Speed pulse frequency converter.
//
// Input stream: tuser selects the item kind (0 capture, 1 tick), tdata[21:0]
// carries the captured sensor frequency in mHz. A capture is written into the
// reading ring in the cycle it is accepted and produces no result. A tick
// emits one result, averaging new readings first when in_ppk is nonzero.
// Output stream: tdata holds the drive frequency, set speed and vehicle speed,
// tuser the out-of-range flag. Registers sit on an APB port at word addresses
// 0x0..0xC; the user must write them only when idle, which is not enforced.
//
// Captures are taken back to back, one per cycle, while no tick is in
// progress. A tick runs the bit-serial divider once per reading to average
// and once more for the mean; with nothing to average it skips the divider.
// The next item is taken the cycle after the result is loaded. The result
// register frees the input side: a new item is taken while a result is still
// pending, and a tick stalls before its result only if the previous one has
// not been taken yet. Reset clears the ring write index, the reading count,
// the held speed and frequency and resets the registers; ring contents are
// not cleared, only entries written since the last averaging tick are read.
`default_nettype none

module speed_pulse_frequency_converter #(
  parameter int unsigned RING_DEPTH = 10
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [21:0] frequency_mhz
  input  wire logic        s_axis_tuser,   // [0] req_type
  // Result items
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [87:0]      m_axis_tdata,   // [24:0] output_frequency_mhz,
                                           // [48:25] set_speed_kmph,
                                           // [80:49] vehicle_speed_mph
  output logic             m_axis_tuser,   // [0] speed_out_of_range
  // Configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import spfc_pkg::*;

  cfg_t     cfg_q;
  cmd_t     cmd;
  sts_t     sts;
  reg_idx_e reg_idx;
  logic     cfg_we;

  logic [OFREQ_W-1:0] out_freq;
  logic [SET_W-1:0]   set_speed;
  logic [SPEED_W-1:0] veh_speed;

  // Register file
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.manual_mode  <= 1'b0;
      cfg_q.manual_speed <= MANUAL_RESET;
      cfg_q.in_ppk       <= '0;
      cfg_q.out_ppk      <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_OUTPUT_MODE:  cfg_q.manual_mode  <= pwdata[0];
        REG_MANUAL_SPEED: cfg_q.manual_speed <= pwdata[MANUAL_W-1:0];
        REG_IN_PPK:       cfg_q.in_ppk       <= pwdata[PPK_W-1:0];
        REG_OUT_PPK:      cfg_q.out_ppk      <= pwdata[PPK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_OUTPUT_MODE:  prdata = {31'd0, cfg_q.manual_mode};
      REG_MANUAL_SPEED: prdata = {23'd0, cfg_q.manual_speed};
      REG_IN_PPK:       prdata = {16'd0, cfg_q.in_ppk};
      REG_OUT_PPK:      prdata = {16'd0, cfg_q.out_ppk};
      default:          prdata = '0;
    endcase
  end

  spfc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_kind_i  (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  spfc_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .freq_i         (s_axis_tdata[FREQ_W-1:0]),
    .m_valid_o      (m_axis_tvalid),
    .m_ready_i      (m_axis_tready),
    .out_freq_o     (out_freq),
    .set_speed_o    (set_speed),
    .veh_speed_o    (veh_speed),
    .out_of_range_o (m_axis_tuser)
  );

  assign m_axis_tdata = {7'd0, veh_speed, set_speed, out_freq};

endmodule

`default_nettype wire

[tb/tb_speed_pulse_frequency_converter.sv]
`default_nettype none

module tb_speed_pulse_frequency_converter;
  timeunit 1ns;
  timeprecision 1ps;

  import spfc_pkg::*;

  localparam int unsigned RING_DEPTH    = 10;
  localparam int unsigned FREQ_MAX      = 4194303;
  // Leave margin for the worst tick and for pipelined items
  localparam int unsigned SETTLE_CYCLES = 600;
  localparam int unsigned CYCLE_LIMIT   = 4000000;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_ITEMS   = 112;

  typedef struct packed {
    logic [OFREQ_W-1:0] drive_freq;
    logic [SET_W-1:0]   set_speed;
    logic [SPEED_W-1:0] vehicle_mph;
    logic               out_of_range;
  } speed_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  wire logic   s_axis_tready;
  logic [23:0] s_axis_tdata = '0;    // [21:0] frequency_mhz
  logic        s_axis_tuser = 1'b0;  // [0] req_type
  wire logic        m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  wire logic [87:0] m_axis_tdata;    // [24:0] output_frequency_mhz, [48:25] set_speed_kmph,
                                     // [80:49] vehicle_speed_mph
  wire logic        m_axis_tuser;    // [0] speed_out_of_range
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire logic [31:0] prdata;
  wire logic        pready;

  // Predictor state
  logic                  cfg_manual_mode = 1'b0;
  logic [MANUAL_W-1:0]   cfg_manual = MANUAL_RESET;
  logic [PPK_W-1:0]      cfg_in_ppk = '0;
  logic [PPK_W-1:0]      cfg_out_ppk = '0;
  logic [FREQ_W-1:0]     freq_ring [RING_DEPTH];
  int unsigned           ring_wr = 0;
  int unsigned           fresh_cnt = 0;
  logic [SPEED_W-1:0]    vehicle_mph = '0;
  logic [31:0]           held_freq = '0;

  speed_result_t expected_speeds[$];
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;
  logic          steady = 1'b0;  // no idling on either side while set

  speed_pulse_frequency_converter #(.RING_DEPTH(RING_DEPTH)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Receiver stalls
  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 31);
  end

  // Work out the result of one accepted item
  task automatic predict_item(input logic kind, input logic [FREQ_W-1:0] freq);
    longint unsigned total;
    int              chosen;
    logic            range_err;
    longint          drive;
    speed_result_t   res;
    if (kind == REQ_CAPTURE) begin
      freq_ring[ring_wr] = freq;
      ring_wr = (ring_wr + 1) % RING_DEPTH;
      if (fresh_cnt < RING_DEPTH) fresh_cnt++;
    end else begin
      // zero pulses per km/h: keep the held speed and pending readings
      if (cfg_in_ppk != 0) begin
        if (fresh_cnt == 0) begin
          vehicle_mph = '0;
        end else begin
          total = 0;
          for (int k = 0; k < fresh_cnt; k++) begin
            total += (longint'(freq_ring[(ring_wr + RING_DEPTH - 1 - k) % RING_DEPTH]) * 1000)
                     / cfg_in_ppk;
          end
          vehicle_mph = SPEED_W'(total / fresh_cnt);
          fresh_cnt = 0;
        end
      end
      if (cfg_manual_mode) begin
        chosen = $signed(cfg_manual);
      end else begin
        chosen = int'(vehicle_mph / 32'd1000);
      end
      range_err = (chosen > SPEED_MAX_KMPH) || (chosen < SPEED_MIN_KMPH);
      if (!range_err) begin
        drive = longint'(chosen) * longint'(cfg_out_ppk);
        held_freq = drive[31:0];
      end
      res.drive_freq   = held_freq[OFREQ_W-1:0];
      res.set_speed    = chosen[SET_W-1:0];
      res.vehicle_mph  = vehicle_mph;
      res.out_of_range = range_err;
      expected_speeds.push_back(res);
    end
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s expected %0h got %0h", $realtime, what, want, got);
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin : check_results
    speed_result_t got;
    speed_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.drive_freq   = m_axis_tdata[24:0];
      got.set_speed    = m_axis_tdata[48:25];
      got.vehicle_mph  = m_axis_tdata[80:49];
      got.out_of_range = m_axis_tuser;
      if (expected_speeds.size() == 0) begin
        note_mismatch("unexpected result, drive freq", '0, 32'(got.drive_freq));
      end else begin
        want = expected_speeds.pop_front();
        if (got.drive_freq != want.drive_freq)
          note_mismatch("drive freq", 32'(want.drive_freq), 32'(got.drive_freq));
        if (got.set_speed != want.set_speed)
          note_mismatch("set speed", 32'(want.set_speed), 32'(got.set_speed));
        if (got.vehicle_mph != want.vehicle_mph)
          note_mismatch("vehicle speed", want.vehicle_mph, got.vehicle_mph);
        if (got.out_of_range != want.out_of_range)
          note_mismatch("range flag", 32'(want.out_of_range), 32'(got.out_of_range));
      end
    end
  end

  // Send one item, with random idle cycles in front unless steady is set
  task automatic send_item(input logic kind, input logic [FREQ_W-1:0] freq);
    while (!steady && $urandom_range(99) < 31) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {2'b00, freq};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_item(kind, freq);
  endtask

  // APB write: setup then access
  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_OUTPUT_MODE:  cfg_manual_mode = value[0];
      REG_MANUAL_SPEED: cfg_manual = value[MANUAL_W-1:0];
      REG_IN_PPK:       cfg_in_ppk = value[PPK_W-1:0];
      REG_OUT_PPK:      cfg_out_ppk = value[PPK_W-1:0];
      default: ;
    endcase
  endtask

  // Drain all results, then wait a settling time
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_speeds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly frequencies that land near the legal speed range
  function automatic logic [FREQ_W-1:0] pick_freq();
    longint unsigned f;
    if (cfg_in_ppk != 0 && $urandom_range(99) < 70) begin
      f = longint'($urandom_range(260)) * cfg_in_ppk + $urandom_range(cfg_in_ppk - 1);
      if (f > FREQ_MAX) f = FREQ_MAX;
    end else begin
      f = $urandom_range(FREQ_MAX);
    end
    return f[FREQ_W-1:0];
  endfunction

  // Register defaults: measurement off, held speed used
  task automatic test_reset_defaults();
    send_item(REQ_TICK, '0);
    send_item(REQ_CAPTURE, 22'h2AAAAA);
    send_item(REQ_TICK, 22'h155555);
  endtask

  // Smallest and largest frequencies, tick without new readings
  task automatic test_measured_extremes();
    wait_idle();
    write_reg(REG_IN_PPK, 32'd1);
    write_reg(REG_OUT_PPK, 32'd65535);
    write_reg(REG_OUTPUT_MODE, 32'd0);
    send_item(REQ_CAPTURE, '0);
    send_item(REQ_TICK, '0);
    send_item(REQ_CAPTURE, FREQ_W'(FREQ_MAX));
    send_item(REQ_TICK, '0);
    send_item(REQ_TICK, FREQ_W'(FREQ_MAX));
  endtask

  // More captures than ring entries: only the newest are averaged
  task automatic test_reading_saturation();
    wait_idle();
    write_reg(REG_IN_PPK, 32'd1000);
    write_reg(REG_OUT_PPK, 32'd1000);
    for (int k = 0; k < RING_DEPTH + 1; k++) begin
      send_item(REQ_CAPTURE, FREQ_W'((k + 1) * 20000 + k));
    end
    send_item(REQ_TICK, '0);
  endtask

  // Measurement off keeps readings; they convert at the next enabled tick
  task automatic test_disabled_measurement();
    wait_idle();
    write_reg(REG_IN_PPK, 32'd0);
    send_item(REQ_CAPTURE, 22'd150000);
    send_item(REQ_TICK, '0);
    wait_idle();
    write_reg(REG_IN_PPK, 32'd500);
    send_item(REQ_TICK, '0);
  endtask

  // Manual speed at and beyond the range limits
  task automatic test_manual_speed();
    int manual_cases[5] = '{250, -50, 251, -51, -256};
    wait_idle();
    write_reg(REG_OUTPUT_MODE, 32'd1);
    write_reg(REG_OUT_PPK, 32'd65535);
    foreach (manual_cases[i]) begin
      wait_idle();
      write_reg(REG_MANUAL_SPEED, 32'(manual_cases[i]));
      send_item(REQ_TICK, '0);
    end
  endtask

  // Bursts of captures closed by a tick, some stray items, new settings per phase
  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned burst;
    int unsigned sel;
    logic [31:0] value;
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      sel = $urandom_range(9);
      if (sel == 0) value = 0;
      else if (sel == 1) value = 1;
      else if (sel == 2) value = 65535;
      else value = $urandom_range(16000, 100);
      write_reg(REG_IN_PPK, value);
      sel = $urandom_range(9);
      if (sel == 0) value = 0;
      else if (sel <= 2) value = 65535;
      else value = $urandom_range(65535);
      write_reg(REG_OUT_PPK, value);
      write_reg(REG_OUTPUT_MODE, 32'($urandom_range(99) < 20));
      if ($urandom_range(99) < 30) value = $urandom_range(511);
      else value = 32'(int'($urandom_range(300)) - 50);
      write_reg(REG_MANUAL_SPEED, value);
      steady = (phase == 3);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(99) < 85) begin
          burst = $urandom_range(12);
          repeat (burst) send_item(REQ_CAPTURE, pick_freq());
          send_item(REQ_TICK, FREQ_W'($urandom));
          sent += burst + 1;
        end else begin
          send_item(logic'($urandom_range(1)), FREQ_W'($urandom));
          sent++;
        end
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_measured_extremes();
    test_reading_saturation();
    test_disabled_measurement();
    test_manual_speed();
    test_random_traffic();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
